// ----- sv/pir_pkg.sv -----
// Shared types and constants of the priority interrupt queue.
package pir_pkg;
  localparam logic [1:0] OP_RAISE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam int PRIO_W = 3;
  localparam int VEC_W  = 8;
  localparam int ADDR_W = 10;
  localparam int OCC_W  = 5;
  localparam logic [ADDR_W-1:0] VECTOR_BASE = 10'h100;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [VEC_W-1:0]  vec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

// ----- sv/pir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/priority_interrupt_queue.sv -----
// Priority interrupt queue top level: request handshake, queue sequencer and entry RAM.
// Raise and query requests go straight to the ST_FIN state, which registers the result.
// Acknowledge does one RAM scan for the top request, then, unless that entry is the last,
// a read-modify-write sweep that closes the gap behind it.
// One request is worked on at a time; a new one is taken while a result waits.
// Synchronous reset empties the queue; entry RAM contents are not cleared.
module priority_interrupt_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tuser: op[1:0]
  input  logic [1:0]  s_tuser,
  // tdata: req_priority[2:0], device_vector[10:3], cpu_level[13:11], zero fill
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: interrupt_pending[0], vector_address[10:1], granted_priority[13:11],
  // granted[14], dropped_full[15], empty_error[16], occupancy[21:17], zero fill
  output logic [23:0] m_tdata
);
  import pir_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [PRIO_W-1:0] topmax;
  logic [PRIO_W-1:0] lvl;
  logic              issuing;
  logic [CW-1:0]     rd_idx;
  logic              dv;
  logic [AW-1:0]     d_idx;
  logic [PRIO_W-1:0] best;
  logic [AW-1:0]     best_idx;
  logic [VEC_W-1:0]  best_vec;
  logic [PRIO_W-1:0] second;
  logic              r_granted;
  logic              r_dropped;
  logic              r_empty;
  logic [ADDR_W-1:0] r_vaddr;
  logic [PRIO_W-1:0] r_gprio;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic              s_acc;
  logic [1:0]        in_op;
  logic [PRIO_W-1:0] in_prio;
  logic [VEC_W-1:0]  in_vec;
  logic [CW-1:0]     cnt_m1;
  logic              full;
  logic [PRIO_W-1:0] best_upd;
  logic [AW-1:0]     best_idx_upd;
  logic [VEC_W-1:0]  best_vec_upd;
  logic [PRIO_W-1:0] second_upd;
  logic              out_free;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign in_op     = s_tuser;
  assign in_prio   = s_tdata[2:0];
  assign in_vec    = s_tdata[10:3];
  assign cnt_m1    = count - CW'(1);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign out_free  = !m_tvalid || m_tready;
  assign ram_rdata = entry_t'(ram_rbits);

  always_comb begin
    best_upd     = best;
    best_idx_upd = best_idx;
    best_vec_upd = best_vec;
    second_upd   = second;
    if (d_idx == '0) begin
      best_upd     = ram_rdata.prio;
      best_idx_upd = d_idx;
      best_vec_upd = ram_rdata.vec;
      second_upd   = '0;
    end else if (ram_rdata.prio > best) begin
      best_upd     = ram_rdata.prio;
      best_idx_upd = d_idx;
      best_vec_upd = ram_rdata.vec;
      second_upd   = best;
    end else if (ram_rdata.prio > second) begin
      second_upd = ram_rdata.prio;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = '{prio: in_prio, vec: in_vec};
    if (state == ST_IDLE) begin
      ram_we = s_acc && (in_op == OP_RAISE) && !full;
    end else if (state == ST_SHIFT) begin
      ram_we    = dv;
      ram_waddr = d_idx;
      ram_wdata = ram_rdata;
    end
  end

  pir_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rbits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      issuing  <= 1'b0;
      dv       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            lvl       <= s_tdata[13:11];
            r_granted <= 1'b0;
            r_dropped <= (in_op == OP_RAISE) && full;
            r_empty   <= (in_op == OP_ACK) && (count == '0);
            r_vaddr   <= '0;
            r_gprio   <= '0;
            unique case (in_op)
              OP_RAISE: begin
                state <= ST_FIN;
                if (!full) begin
                  count  <= count + CW'(1);
                  topmax <= (count == '0 || in_prio > topmax) ? in_prio : topmax;
                end
              end
              OP_ACK: begin
                if (count == '0) begin
                  state <= ST_FIN;
                end else begin
                  state   <= ST_SCAN;
                  issuing <= 1'b1;
                  rd_idx  <= '0;
                  dv      <= 1'b0;
                end
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          dv    <= issuing;
          d_idx <= rd_idx[AW-1:0];
          if (issuing) begin
            if (rd_idx == cnt_m1) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + CW'(1);
            end
          end
          if (dv) begin
            best     <= best_upd;
            best_idx <= best_idx_upd;
            best_vec <= best_vec_upd;
            second   <= second_upd;
            if (CW'(d_idx) == cnt_m1) begin
              r_granted <= 1'b1;
              r_gprio   <= best_upd;
              r_vaddr   <= VECTOR_BASE + {1'b0, best_vec_upd, 1'b0};
              if (CW'(best_idx_upd) == cnt_m1) begin
                count  <= cnt_m1;
                topmax <= second_upd;
                state  <= ST_FIN;
              end else begin
                issuing <= 1'b1;
                rd_idx  <= CW'(best_idx_upd) + CW'(1);
                state   <= ST_SHIFT;
              end
            end
          end
        end
        ST_SHIFT: begin
          dv    <= issuing;
          d_idx <= rd_idx[AW-1:0] - AW'(1);
          if (issuing) begin
            if (rd_idx == cnt_m1) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + CW'(1);
            end
          end
          if (dv && (CW'(d_idx) == cnt_m1 - CW'(1))) begin
            count  <= cnt_m1;
            topmax <= second;
            state  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, OCC_W'(count), r_empty, r_dropped, r_granted,
                         r_gprio, r_vaddr, (count != '0) && (topmax > lvl)};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_grant_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[14] && (m_tdata[15] || m_tdata[16])))
    else $error("grant together with an error flag");

  a_raise_count: assert property (@(posedge clk) disable iff (rst)
    (s_acc && in_op == OP_RAISE && !full) |=> count == $past(count) + CW'(1))
    else $error("raise did not add an entry");

  a_ack_empty: assert property (@(posedge clk) disable iff (rst)
    (s_acc && in_op == OP_ACK && count == '0) |=> (state == ST_FIN && r_empty))
    else $error("acknowledge on empty queue not flagged");
endmodule
